// ===== hdl/srrr_pkg.sv =====
// Shared types and constants for the selective-repeat receive reorder block.
`default_nettype none

package srrr_pkg;

  localparam int SEQ_W      = 8;
  localparam int HANDLE_W   = 16;
  localparam int LEN_W      = 10;
  localparam int WIN_W      = 6;
  localparam int OP_W       = SEQ_W + 1;
  localparam int CNT_W      = 6;
  localparam int unsigned MAX_PAYLOAD = 1024;
  localparam int unsigned MAX_DRAIN   = 63;
  localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(8);

  localparam logic FUNC_DATA = 1'b0;
  localparam logic FUNC_DONE = 1'b1;

  typedef struct packed {
    logic                func;
    logic                frame_ok;
    logic [SEQ_W-1:0]    seq_num;
    logic [HANDLE_W-1:0] payload_handle;
    logic [LEN_W-1:0]    payload_length;
  } frame_t;

  typedef struct packed {
    logic                ack_valid;
    logic [SEQ_W-1:0]    ack_seq;
    logic                done_reply;
    logic                deliver_valid;
    logic [SEQ_W-1:0]    deliver_seq;
    logic [HANDLE_W-1:0] deliver_handle;
    logic [LEN_W-1:0]    deliver_length;
    logic                last;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_CHECK,
    S_ACK,
    S_DRAIN_RD,
    S_DRAIN_OUT,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== hdl/selective_repeat_receive_reorder.sv =====
// Selective-repeat ARQ receiver: acknowledges frames and delivers them in sequence order.
//
// Channels: frame (valid/stall, frame_t word in) and result (valid/stall, result_t word
// out); cfg_valid/cfg_ready writes the receive window (6 bits, reset value 8).
// One word is handled at a time: frame_stall is high from acceptance until the last
// result of that word has been loaded into the output register.
// A corrupted data frame gives no result. A done message gives one done_reply word,
// loaded from S_DONE. A good data frame first runs the shared subtractor, which takes
// SEQ_SPACE off seq_num in S_REDUCE until it borrows; S_CHECK then finds the window
// distance and writes the buffer, and S_ACK loads the ack word. Each in-order
// delivery then passes S_DRAIN_RD and S_DRAIN_OUT, for the registered read of the
// descriptor memory at the expected sequence.
// Reset clears the expected sequence, all held-valid flags and the output valid flag;
// the descriptor memory needs no clearing since only held slots are read.
// When the receiver holds result_stall, the output word holds and the sequencer waits;
// nothing is dropped. The last field marks the final result of each input word.
`default_nettype none

module selective_repeat_receive_reorder
  import srrr_pkg::*;
#(
  parameter int SEQ_SPACE = 256
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             frame_valid,
  output logic                  frame_stall,
  input  wire frame_t           frame,
  output logic                  result_valid,
  input  wire logic             result_stall,
  output result_t               result,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [WIN_W-1:0] cfg_data
);

  localparam int IDX_W = $clog2(SEQ_SPACE);
  localparam int MEM_W = HANDLE_W + LEN_W;

  state_t state, state_next;

  logic [WIN_W-1:0]    rx_window;
  logic [IDX_W-1:0]    expected_seq, expected_seq_next;
  logic [SEQ_SPACE-1:0] held_valid;
  logic [MEM_W-1:0]    held_mem [SEQ_SPACE];
  logic [MEM_W-1:0]    mem_q;

  logic [SEQ_W-1:0]    seq_r;
  logic [HANDLE_W-1:0] handle_r;
  logic [LEN_W-1:0]    len_sat;
  logic [LEN_W-1:0]    len_r;
  logic                win_r;
  logic [CNT_W-1:0]    drain_cnt;

  logic                accept;
  logic                load_ok;
  logic                load_res;
  result_t             res_next;
  logic                store_en;
  logic                drain_step;
  logic                more;

  // shared subtractor
  logic [OP_W-1:0]     unit_a, unit_b;
  logic [OP_W:0]       unit_diff;
  logic                borrow;
  logic [OP_W-1:0]     fwd_dist;
  logic                in_win;

  assign accept      = frame_valid && !frame_stall;
  assign frame_stall = (state != S_IDLE);
  assign cfg_ready   = 1'b1;
  assign load_ok     = !result_valid || !result_stall;

  assign expected_seq_next = (expected_seq == IDX_W'(SEQ_SPACE - 1)) ? '0
                                                                     : expected_seq + 1'b1;

  always_comb begin
    unit_a = OP_W'(seq_r);
    if (state == S_REDUCE) begin
      unit_b = OP_W'(SEQ_SPACE);
    end else begin
      unit_b = OP_W'(expected_seq);
    end
    unit_diff = {1'b0, unit_a} - {1'b0, unit_b};
    borrow    = unit_diff[OP_W];
    // wrap a negative distance back into the sequence space
    fwd_dist  = borrow ? unit_diff[OP_W-1:0] + OP_W'(SEQ_SPACE) : unit_diff[OP_W-1:0];
    in_win    = fwd_dist < OP_W'(rx_window);
  end

  always_comb begin
    if (32'(frame.payload_length) > MAX_PAYLOAD) begin
      len_sat = LEN_W'(MAX_PAYLOAD);
    end else begin
      len_sat = frame.payload_length;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    load_res   = 1'b0;
    res_next   = '0;
    store_en   = 1'b0;
    drain_step = 1'b0;
    more       = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (frame.func == FUNC_DONE) begin
            state_next = S_DONE;
          end else if (frame.frame_ok) begin
            state_next = S_REDUCE;
          end
        end
      end
      S_REDUCE: begin
        if (borrow) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        store_en   = in_win;
        state_next = S_ACK;
      end
      S_ACK: begin
        if (load_ok) begin
          more               = win_r && held_valid[expected_seq];
          load_res           = 1'b1;
          res_next.ack_valid = 1'b1;
          res_next.ack_seq   = seq_r;
          res_next.last      = !more;
          state_next         = more ? S_DRAIN_RD : S_IDLE;
        end
      end
      S_DRAIN_RD: begin
        state_next = S_DRAIN_OUT;
      end
      S_DRAIN_OUT: begin
        if (load_ok) begin
          more = held_valid[expected_seq_next] &&
                 ((7'(drain_cnt) + 7'd1) < 7'(MAX_DRAIN));
          load_res                = 1'b1;
          drain_step              = 1'b1;
          res_next.deliver_valid  = 1'b1;
          res_next.deliver_seq    = SEQ_W'(expected_seq);
          res_next.deliver_handle = mem_q[MEM_W-1:LEN_W];
          res_next.deliver_length = mem_q[LEN_W-1:0];
          res_next.last           = !more;
          state_next              = more ? S_DRAIN_RD : S_IDLE;
        end
      end
      S_DONE: begin
        if (load_ok) begin
          load_res            = 1'b1;
          res_next.done_reply = 1'b1;
          res_next.last       = 1'b1;
          state_next          = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // frame capture and reduction of the sequence number
  always_ff @(posedge clk) begin
    if (accept) begin
      seq_r    <= frame.seq_num;
      handle_r <= frame.payload_handle;
      len_r    <= len_sat;
    end else if (state == S_REDUCE && !borrow) begin
      seq_r <= unit_diff[SEQ_W-1:0];
    end
    if (state == S_CHECK) begin
      win_r <= in_win;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_window    <= WIN_RESET;
      expected_seq <= '0;
      held_valid   <= '0;
      drain_cnt    <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        rx_window <= cfg_data;
      end
      if (store_en) begin
        held_valid[seq_r[IDX_W-1:0]] <= 1'b1;
      end
      if (state == S_CHECK) begin
        drain_cnt <= '0;
      end else if (drain_step) begin
        held_valid[expected_seq] <= 1'b0;
        expected_seq             <= expected_seq_next;
        drain_cnt                <= drain_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (store_en) begin
      held_mem[seq_r[IDX_W-1:0]] <= {handle_r, len_r};
    end
    mem_q <= held_mem[expected_seq];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_res) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_res) begin
      result <= res_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/srrr_check.sv =====
// Port-level checks on the result channel of the receive reorder block, bound to the top level.
`default_nettype none

module srrr_check
  import srrr_pkg::*;
(
  input wire logic    clk,
  input wire logic    rst,
  input wire logic    result_valid,
  input wire logic    result_stall,
  input wire result_t result
);

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result word changed");

  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $onehot({result.ack_valid, result.done_reply, result.deliver_valid}))
    else $error("result word is not exactly one of ack, done, deliver");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.done_reply |-> result.last)
    else $error("done reply word without last");

  a_clean_fields: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.deliver_valid |->
      result.deliver_seq == '0 && result.deliver_handle == '0 &&
      result.deliver_length == '0)
    else $error("delivery fields set on a non-delivery word");

endmodule

bind selective_repeat_receive_reorder srrr_check u_srrr_check (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

`default_nettype wire
